// ===== rtl/kcp_pkg.sv =====
// Shared types, constants and lookup functions for the keyed cube Polybius codec.
package kcp_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 3;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_CELL_ROT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_SWAP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT0_ROT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT1_ROT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT2_ROT   = 3'd5;

  localparam logic [7:0] CHAR_A     = 8'h61;
  localparam logic [7:0] CHAR_Z     = 8'h7a;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [4:0] SPACE_IDX  = 5'd26;
  localparam logic [3:0] CENTRE_CELL = 4'd4;

  // Ring order around the centre, as x and y, and as cell number y*3+x
  localparam logic [1:0] RING_X [8] = '{2'd0, 2'd1, 2'd2, 2'd2, 2'd2, 2'd1, 2'd0, 2'd0};
  localparam logic [1:0] RING_Y [8] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd2, 2'd2, 2'd2, 2'd1};
  localparam logic [3:0] CELL_OF_RING [8] =
    '{4'd0, 4'd1, 4'd2, 4'd5, 4'd8, 4'd7, 4'd6, 4'd3};

  typedef struct packed {
    logic [2:0] cell_rot;
    logic       backward;
    logic [2:0] centre_swap;
    logic [2:0] slot0_rot;
    logic [2:0] slot1_rot;
    logic [2:0] slot2_rot;
  } key_t;

  // Ring position of a non-centre cell
  function automatic logic [2:0] ring_of_cell(input logic [3:0] cell_no);
    logic [2:0] r;
    unique case (cell_no)
      4'd0:    r = 3'd0;
      4'd1:    r = 3'd1;
      4'd2:    r = 3'd2;
      4'd5:    r = 3'd3;
      4'd8:    r = 3'd4;
      4'd7:    r = 3'd5;
      4'd6:    r = 3'd6;
      4'd3:    r = 3'd7;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  // Character held at a base grid place, index cell*3+slot
  function automatic logic [7:0] char_at(input logic [3:0] cell_no, input logic [1:0] slot);
    logic [4:0] idx;
    idx = 5'(cell_no * 3) + 5'(slot);
    return (idx == SPACE_IDX) ? CHAR_SPACE : (CHAR_A + 8'(idx));
  endfunction

endpackage

// ===== rtl/kcp_key_regs.sv =====
// Key register file of the keyed cube Polybius codec.
module kcp_key_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [kcp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [kcp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output kcp_pkg::key_t                 key_o
);
  import kcp_pkg::*;

  key_t key_q, key_d;

  always_comb begin
    key_d = key_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_CELL_ROT:    key_d.cell_rot    = cfg_data_i;
        REG_DIRECTION:   key_d.backward    = cfg_data_i[0];
        REG_CENTRE_SWAP: key_d.centre_swap = cfg_data_i;
        REG_SLOT0_ROT:   key_d.slot0_rot   = cfg_data_i;
        REG_SLOT1_ROT:   key_d.slot1_rot   = cfg_data_i;
        REG_SLOT2_ROT:   key_d.slot2_rot   = cfg_data_i;
        default:         key_d = key_q;  // drop writes beyond the list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else begin
      key_q <= key_d;
    end
  end

  assign key_o = key_q;

endmodule

// ===== rtl/keyed_cube_polybius_codec_core.sv =====
// Top level of the keyed cube Polybius codec: three-stage lookup pipeline.
// An accepted request passes through the stage 1, stage 2 and output registers to the master side.
// Throughput: one request per cycle; the three stages advance independently,
// so a stall at the output only holds the stages that are full behind it.
// Reset: key registers clear to zero (no rotation, forward, swap with ring 0)
// and all stage valid bits clear; payload registers are not reset.
module keyed_cube_polybius_codec_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [kcp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [kcp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Request stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,  // in_symbol[7:0], in_x, in_y, in_slot, pad
  input  logic                          s_axis_tuser,  // mode: 0 encode, 1 decode
  // Result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [15:0]                   m_axis_tdata,  // out_symbol[7:0], out_x, out_y, out_slot, pad
  output logic                          m_axis_tuser   // not_found
);
  import kcp_pkg::*;

  // Stage 1: request decoded to a base grid place (cell y*3+x and slot)
  typedef struct packed {
    logic       dec;
    logic       hit;
    logic [3:0] cell_no;
    logic [1:0] slot;
  } s1_t;

  // Stage 2: place after the key is applied; for encode the new place,
  // for decode the base place whose character now sits here
  typedef struct packed {
    logic       dec;
    logic       hit;
    logic       centre;
    logic [2:0] ring;
    logic [1:0] slot;
  } s2_t;

  typedef struct packed {
    logic       dec;
    logic       nf;
    logic [7:0] symbol;
    logic [1:0] x;
    logic [1:0] y;
    logic [1:0] slot;
  } out_t;

  key_t key;

  kcp_key_regs u_key_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .key_o       (key)
  );

  // Key writes are always taken
  assign cfg_ready_o = 1'b1;

  // Stage enables: a stage loads when it is empty or its content moves on
  logic en1, en2, en3;
  logic s1_v_q, s2_v_q, out_v_q;
  s1_t  s1_q, s1_d;
  s2_t  s2_q, s2_d;
  out_t out_q, out_d;

  assign en3 = !out_v_q || m_axis_tready;
  assign en2 = !s2_v_q || en3;
  assign en1 = !s1_v_q || en2;
  assign s_axis_tready = en1;

  // ---------------------------------------------------------------- stage 1
  logic [7:0] in_sym;
  logic [1:0] in_x, in_y, in_slot;
  logic [4:0] sym_idx;
  logic [3:0] sym_cell;

  assign in_sym  = s_axis_tdata[7:0];
  assign in_x    = s_axis_tdata[9:8];
  assign in_y    = s_axis_tdata[11:10];
  assign in_slot = s_axis_tdata[13:12];

  always_comb begin
    // Alphabet index of the byte; idx/3 as (idx*11)>>5, exact for idx up to 26
    sym_idx  = (in_sym == CHAR_SPACE) ? SPACE_IDX : 5'(in_sym - CHAR_A);
    sym_cell = 4'((10'(sym_idx) * 10'd11) >> 5);
    s1_d.dec = s_axis_tuser;
    if (s_axis_tuser) begin
      s1_d.hit     = (in_x != 2'd3) && (in_y != 2'd3) && (in_slot != 2'd3);
      s1_d.cell_no = 4'(in_y * 3) + 4'(in_x);
      s1_d.slot    = in_slot;
    end else begin
      s1_d.hit     = (in_sym == CHAR_SPACE) || ((in_sym >= CHAR_A) && (in_sym <= CHAR_Z));
      s1_d.cell_no = sym_cell;
      s1_d.slot    = 2'(sym_idx - 5'(sym_cell * 3));
    end
  end

  // ---------------------------------------------------------------- stage 2
  logic [2:0] slot_rot, total, ring_j, ring_k, enc_pos, dec_src;
  logic       is_centre;

  always_comb begin
    case (s1_q.slot)
      2'd0:    slot_rot = key.slot0_rot;
      2'd1:    slot_rot = key.slot1_rot;
      default: slot_rot = key.slot2_rot;
    endcase
    total     = key.cell_rot + slot_rot;
    is_centre = (s1_q.cell_no == CENTRE_CELL);
    ring_j    = ring_of_cell(s1_q.cell_no);
    // Encode: where the base cell moves to under the ring shift
    enc_pos   = key.backward ? (ring_j - total) : (ring_j + total);
    // Decode: the centre reads the swapped ring place; shift back to the source
    ring_k    = is_centre ? key.centre_swap : ring_j;
    dec_src   = key.backward ? (ring_k + total) : (ring_k - total);

    s2_d.dec  = s1_q.dec;
    s2_d.hit  = s1_q.hit;
    s2_d.slot = s1_q.slot;
    if (s1_q.dec) begin
      s2_d.centre = !is_centre && (ring_j == key.centre_swap);
      s2_d.ring   = dec_src;
    end else if (is_centre) begin
      s2_d.centre = 1'b0;
      s2_d.ring   = key.centre_swap;
    end else begin
      s2_d.centre = (enc_pos == key.centre_swap);
      s2_d.ring   = enc_pos;
    end
  end

  // ---------------------------------------------------------------- stage 3
  logic [3:0] src_cell;

  always_comb begin
    src_cell = s2_q.centre ? CENTRE_CELL : CELL_OF_RING[s2_q.ring];
    out_d    = '0;
    out_d.dec = s2_q.dec;
    out_d.nf  = !s2_q.hit;
    if (s2_q.hit) begin
      if (s2_q.dec) begin
        out_d.symbol = char_at(src_cell, s2_q.slot);
      end else begin
        out_d.x    = s2_q.centre ? 2'd1 : RING_X[s2_q.ring];
        out_d.y    = s2_q.centre ? 2'd1 : RING_Y[s2_q.ring];
        out_d.slot = s2_q.slot;
      end
    end
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (en1) s1_v_q  <= s_axis_tvalid;
      if (en2) s2_v_q  <= s1_v_q;
      if (en3) out_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) s1_q  <= s1_d;
    if (en2) s2_q  <= s2_d;
    if (en3) out_q <= out_d;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {2'b00, out_q.slot, out_q.y, out_q.x, out_q.symbol};
  assign m_axis_tuser  = out_q.nf;

  // ---------------------------------------------------------------- checks
  // An accepted request always lands in stage 1
  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> s1_v_q)
    else $error("accepted request not held in stage 1");

  // A full stage 1 held back by stage 2 keeps its content
  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && !en2 |=> s1_v_q && $stable(s1_q))
    else $error("stage 1 lost or changed while stalled");

  // A decode hit always yields a printable grid character
  a_dec_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q.dec && !out_q.nf |-> out_q.symbol != 8'd0)
    else $error("decode hit gave an empty character");

  // An encode hit always lies inside the 3x3x3 grid
  a_enc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_q.dec && !out_q.nf |->
      out_q.x != 2'd3 && out_q.y != 2'd3 && out_q.slot != 2'd3)
    else $error("encode hit outside the grid");

endmodule
